@@ rtl/ddq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ddq_pkg
// Shared types, opcodes and constants of the resizable double-ended queue.
// ----------------------------------------------------------------------------
package ddq_pkg;

  localparam int MAX_DEPTH_DEF  = 1024;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int MIN_CAP        = 10;

  localparam int OPC_W  = 3;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 11;
  localparam int CAPO_W = 12;
  localparam int CFG_W  = 11;

  localparam logic [OPC_W-1:0] OP_QUERY      = 3'd0;
  localparam logic [OPC_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OPC_W-1:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [OPC_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OPC_W-1:0] OP_POP_BACK   = 3'd4;
  localparam logic [OPC_W-1:0] OP_POP_BOTH   = 3'd5;
  localparam logic [OPC_W-1:0] OP_CLEAR      = 3'd6;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [OPC_W-1:0]        opcode;
    logic signed [VAL_W-1:0] data_value;
  } ddq_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] back_value;
    logic [CNT_W-1:0]        element_count;
    logic [CAPO_W-1:0]       capacity;
    logic                    is_empty;
  } ddq_out_t;

endpackage
`default_nettype wire

@@ rtl/ddq_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ddq_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module ddq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

@@ rtl/ddq_next.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ddq_next
// Next pointers, count and capacity for one operation, plus the RAM write.
// ----------------------------------------------------------------------------
module ddq_next #(
  parameter int MAX_DEPTH = ddq_pkg::MAX_DEPTH_DEF
) (
  input  wire logic [ddq_pkg::OPC_W-1:0]          opcode,
  input  wire logic [$clog2(MAX_DEPTH)-1:0]       head,
  input  wire logic [$clog2(MAX_DEPTH)-1:0]       tail,
  input  wire logic [$clog2(MAX_DEPTH+1)-1:0]     occ,
  input  wire logic [$clog2(2*MAX_DEPTH)-1:0]     cap,
  input  wire logic [$clog2(MAX_DEPTH+1)-1:0]     base,
  output logic      [$clog2(MAX_DEPTH)-1:0]       head_nxt,
  output logic      [$clog2(MAX_DEPTH)-1:0]       tail_nxt,
  output logic      [$clog2(MAX_DEPTH+1)-1:0]     occ_nxt,
  output logic      [$clog2(2*MAX_DEPTH)-1:0]     cap_nxt,
  output logic      [$clog2(MAX_DEPTH+1)-1:0]     base_nxt,
  output logic      [ddq_pkg::STAT_W-1:0]         status,
  output logic                                    wr_en,
  output logic      [$clog2(MAX_DEPTH)-1:0]       wr_addr
);
  import ddq_pkg::*;

  localparam int PTR_W = $clog2(MAX_DEPTH);
  localparam int OCC_W = $clog2(MAX_DEPTH+1);
  localparam int CAP_W = $clog2(2*MAX_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (int'(p) + 1 >= MAX_DEPTH) return '0;
    return p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    if (p == '0) return PTR_W'(MAX_DEPTH - 1);
    return p - 1'b1;
  endfunction

  function automatic logic [CAP_W-1:0] shrink(input logic [OCC_W-1:0] n,
                                              input logic [CAP_W-1:0] c,
                                              input logic [OCC_W-1:0] b);
    if (int'(n) <= int'(c >> 2) && int'(c) >= 2 * int'(b)) return c >> 1;
    return c;
  endfunction

  logic [OCC_W-1:0] occ_mid;
  logic [CAP_W-1:0] cap_mid;

  always_comb begin
    head_nxt = head;
    tail_nxt = tail;
    occ_nxt  = occ;
    cap_nxt  = cap;
    base_nxt = base;
    status   = STAT_OK;
    wr_en    = 1'b0;
    wr_addr  = tail;
    occ_mid  = occ;
    cap_mid  = cap;
    unique case (opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (int'(occ) >= MAX_DEPTH) begin
          status = STAT_FULL;
        end else begin
          if (int'(occ) >= int'(cap)) begin
            cap_nxt = cap << 1;
          end
          occ_nxt = occ + 1'b1;
          wr_en   = 1'b1;
          if (opcode == OP_PUSH_FRONT) begin
            head_nxt = ptr_dec(head);
            wr_addr  = ptr_dec(head);
          end else begin
            tail_nxt = ptr_inc(tail);
          end
        end
      end
      OP_POP_FRONT: begin
        if (occ == '0) begin
          status = STAT_EMPTY;
        end else begin
          head_nxt = ptr_inc(head);
          occ_nxt  = occ - 1'b1;
          cap_nxt  = shrink(occ - 1'b1, cap, base);
        end
      end
      OP_POP_BACK: begin
        if (occ == '0) begin
          status = STAT_EMPTY;
        end else begin
          tail_nxt = ptr_dec(tail);
          occ_nxt  = occ - 1'b1;
          cap_nxt  = shrink(occ - 1'b1, cap, base);
        end
      end
      OP_POP_BOTH: begin
        if (occ == '0) begin
          status = STAT_EMPTY;
        end else begin
          head_nxt = ptr_inc(head);
          occ_mid  = occ - 1'b1;
          cap_mid  = shrink(occ_mid, cap, base);
          occ_nxt  = occ_mid;
          cap_nxt  = cap_mid;
          if (occ_mid == '0) begin
            status = STAT_EMPTY;
          end else begin
            tail_nxt = ptr_dec(tail);
            occ_nxt  = occ_mid - 1'b1;
            cap_nxt  = shrink(occ_mid - 1'b1, cap_mid, base);
          end
        end
      end
      OP_CLEAR: begin
        head_nxt = '0;
        tail_nxt = '0;
        occ_nxt  = '0;
        cap_nxt  = CAP_W'(MIN_CAP);
        base_nxt = OCC_W'(MIN_CAP);
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/resizable_double_ended_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// resizable_double_ended_queue
// Double-ended queue over a RAM ring with a growing and shrinking capacity.
// ----------------------------------------------------------------------------
// Input: an operation word on in_item is taken at a clock edge with start high
// and busy low. Operations: query, push front, push back, pop front, pop back,
// pop both ends, clear.
// Output: one result word per operation on out_item, valid for exactly one
// cycle while out_strobe is high. The receiver cannot stall; a result is
// never held back.
// Sequence: pointers, count and capacity update at the accepting edge
// together with any RAM write; in the ST_READ state that follows, the front
// and back words are read through the two registered RAM read ports; the
// ST_RESP state that comes next presents the result with out_strobe high.
// Busy stays high through ST_READ and ST_RESP, so a new operation is taken
// only once the result of the last one has been presented.
// Configuration: a write on cfg_we/cfg_wdata loads the initial capacity
// (clamped to 10..MAX_DEPTH) and empties the queue. Write only while idle.
// Reset: empty queue, capacity and shrink base 10. The RAM needs no clearing
// pass, since only words that were pushed are ever read.
// ----------------------------------------------------------------------------
module resizable_double_ended_queue #(
  parameter int MAX_DEPTH  = ddq_pkg::MAX_DEPTH_DEF,
  parameter int DATA_WIDTH = ddq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire ddq_pkg::ddq_in_t            in_item,
  output logic                             out_strobe,
  output ddq_pkg::ddq_out_t                out_item,
  input  wire logic                        cfg_we,
  input  wire logic [ddq_pkg::CFG_W-1:0]   cfg_wdata
);
  import ddq_pkg::*;

  localparam int PTR_W = $clog2(MAX_DEPTH);
  localparam int OCC_W = $clog2(MAX_DEPTH+1);
  localparam int CAP_W = $clog2(2*MAX_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  function automatic int clamp_cap(input logic [CFG_W-1:0] v);
    if (int'(v) < MIN_CAP) return MIN_CAP;
    if (int'(v) > MAX_DEPTH) return MAX_DEPTH;
    return int'(v);
  endfunction

  logic [1:0]          state_r, state_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [OCC_W-1:0]    occ_r, occ_nxt;
  logic [CAP_W-1:0]    cap_r, cap_nxt;
  logic [OCC_W-1:0]    base_r, base_nxt;
  logic [STAT_W-1:0]   status_r, status_nxt;

  logic [PTR_W-1:0]    upd_head;
  logic [PTR_W-1:0]    upd_tail;
  logic [OCC_W-1:0]    upd_occ;
  logic [CAP_W-1:0]    upd_cap;
  logic [OCC_W-1:0]    upd_base;
  logic [STAT_W-1:0]   upd_status;
  logic                upd_we;
  logic [PTR_W-1:0]    upd_waddr;

  logic                accept;
  logic [PTR_W-1:0]    back_addr;
  logic [DATA_WIDTH-1:0] rd_front;
  logic [DATA_WIDTH-1:0] rd_back;
  logic                empty;
  logic [PTR_W-1:0]    ring_dist;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  ddq_next #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_next (
    .opcode   (in_item.opcode),
    .head     (head_r),
    .tail     (tail_r),
    .occ      (occ_r),
    .cap      (cap_r),
    .base     (base_r),
    .head_nxt (upd_head),
    .tail_nxt (upd_tail),
    .occ_nxt  (upd_occ),
    .cap_nxt  (upd_cap),
    .base_nxt (upd_base),
    .status   (upd_status),
    .wr_en    (upd_we),
    .wr_addr  (upd_waddr)
  );

  assign back_addr = (tail_r == '0) ? PTR_W'(MAX_DEPTH - 1) : tail_r - 1'b1;

  ddq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (accept && upd_we),
    .waddr   (upd_waddr),
    .wdata   (DATA_WIDTH'($unsigned(in_item.data_value))),
    .raddr_a (head_r),
    .raddr_b (back_addr),
    .rdata_a (rd_front),
    .rdata_b (rd_back)
  );

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    occ_nxt    = occ_r;
    cap_nxt    = cap_r;
    base_nxt   = base_r;
    status_nxt = status_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_RESP;
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_we) begin
      head_nxt = '0;
      tail_nxt = '0;
      occ_nxt  = '0;
      cap_nxt  = CAP_W'(clamp_cap(cfg_wdata));
      base_nxt = OCC_W'(clamp_cap(cfg_wdata));
    end else if (accept) begin
      head_nxt   = upd_head;
      tail_nxt   = upd_tail;
      occ_nxt    = upd_occ;
      cap_nxt    = upd_cap;
      base_nxt   = upd_base;
      status_nxt = upd_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      occ_r   <= '0;
      cap_r   <= CAP_W'(MIN_CAP);
      base_r  <= OCC_W'(MIN_CAP);
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      occ_r   <= occ_nxt;
      cap_r   <= cap_nxt;
      base_r  <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  assign empty      = (occ_r == '0);
  assign out_strobe = (state_r == ST_RESP);

  always_comb begin
    out_item.status        = status_r;
    out_item.front_value   = empty ? '0 : VAL_W'(rd_front);
    out_item.back_value    = empty ? '0 : VAL_W'(rd_back);
    out_item.element_count = CNT_W'(occ_r);
    out_item.capacity      = CAPO_W'(cap_r);
    out_item.is_empty      = empty;
  end

  assign ring_dist = (tail_r >= head_r) ? tail_r - head_r
                   : PTR_W'(int'(tail_r) + MAX_DEPTH - int'(head_r));

  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !cfg_we |-> ##2 out_strobe)
    else $error("result strobe missing two cycles after accept");

  a_ring_count: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(occ_r) == MAX_DEPTH) ? (ring_dist == '0) : (int'(ring_dist) == int'(occ_r)))
    else $error("head/tail distance disagrees with count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(occ_r) <= MAX_DEPTH)
    else $error("count beyond physical depth");

  a_cap_floor: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cap_r) >= int'(base_r))
    else $error("capacity below shrink base");

endmodule
`default_nettype wire
